// ===== hdl/stl_pkg.sv =====
// Shared types and constants for the script token splitter.
package stl_pkg;

  // Default configuration.
  localparam int STL_POS_BITS   = 16;
  localparam int STL_FIFO_DEPTH = 4;

  // Token kinds.
  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_QUOTED = 2'd1;
  localparam logic [1:0] KIND_PUNCT  = 2'd2;

  // Characters with a special meaning to the lexer.
  localparam logic [15:0] CH_LBRACE  = 16'h007B;
  localparam logic [15:0] CH_RBRACE  = 16'h007D;
  localparam logic [15:0] CH_LPAREN  = 16'h0028;
  localparam logic [15:0] CH_RPAREN  = 16'h0029;
  localparam logic [15:0] CH_APOS    = 16'h0027;
  localparam logic [15:0] CH_COLON   = 16'h003A;
  localparam logic [15:0] CH_SPACE   = 16'h0020;
  localparam logic [15:0] CH_SLASH   = 16'h002F;
  localparam logic [15:0] CH_DQUOTE  = 16'h0022;
  localparam logic [15:0] CH_NEWLINE = 16'h000A;

  // One token record.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic        closed;
    logic [15:0] punct_char;
  } stl_rec_t;

  // All records caused by one character: one or two.
  typedef struct packed {
    logic     two;
    stl_rec_t rec0;
    stl_rec_t rec1;
  } stl_entry_t;

endpackage

// ===== hdl/script_token_splitter.sv =====
// Path: a token record goes from the front end into the entry queue and then into the
// record register of the back end, where it waits on the output until it is taken.
// Throughput: one character per cycle while the queue is not full; a character that
// closes two tokens takes a second output beat, and the entry queue absorbs such bursts.
// Output: one record per cycle when popped, set by the back end's single record register.
// Reset: synchronous, active low; clears the lexer mode, position, queue and output valid.
// Top level of the script token splitter.
module script_token_splitter #(
  parameter int POS_BITS   = stl_pkg::STL_POS_BITS,
  parameter int FIFO_DEPTH = stl_pkg::STL_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_character,
  input  logic        in_final_char,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [15:0] out_offset,
  output logic [15:0] out_length,
  output logic        out_closed,
  output logic [15:0] out_punct_char,
  output logic        out_last_of_run
);
  import stl_pkg::*;

  stl_entry_t wr_data, rd_data;
  logic       wr_en, rd_en, q_full, q_empty, in_beat;

  assign full    = q_full;
  assign in_beat = push && !q_full;

  // Character classification and lexer state.
  stl_front #(.POS_BITS(POS_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_beat),
    .in_char (in_character),
    .in_fin  (in_final_char),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  // Entry queue.
  stl_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_data(wr_data),
    .full   (q_full),
    .rd_en  (rd_en),
    .rd_data(rd_data),
    .empty  (q_empty)
  );

  // Record output.
  stl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rd_data        (rd_data),
    .q_empty        (q_empty),
    .rd_en          (rd_en),
    .empty          (empty),
    .pop            (pop),
    .out_kind       (out_kind),
    .out_offset     (out_offset),
    .out_length     (out_length),
    .out_closed     (out_closed),
    .out_punct_char (out_punct_char),
    .out_last_of_run(out_last_of_run)
  );

endmodule

// ===== hdl/stl_front.sv =====
// Front end: classifies characters, tracks the lexer mode and builds token records.
module stl_front #(
  parameter int POS_BITS = stl_pkg::STL_POS_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [15:0]         in_char,
  input  logic                in_fin,
  output logic                wr_en,
  output stl_pkg::stl_entry_t wr_data
);
  import stl_pkg::*;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_WORD    = 5'b00010,
    MODE_SLASH   = 5'b00100,
    MODE_QUOTE   = 5'b01000,
    MODE_COMMENT = 5'b10000
  } stl_mode_t;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  stl_mode_t             mode_r, mode_mid, mode_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt, ts_r, ts_nxt, end_incl;
  logic [15:0]           c_eff;
  logic                  emit_a, emit_b;
  stl_rec_t              rec_a, rec_b;

  function automatic logic is_sep(input logic [15:0] c);
    return c <= CH_SPACE;
  endfunction

  function automatic logic is_punct(input logic [15:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_APOS) || (c == CH_COLON);
  endfunction

  function automatic logic is_delim(input logic [15:0] c);
    return is_sep(c) || is_punct(c) || (c == CH_DQUOTE);
  endfunction

  function automatic logic [POS_BITS-1:0] span_f(input logic [POS_BITS-1:0] e,
                                                 input logic [POS_BITS-1:0] s);
    return (e >= s) ? e - s : '0;
  endfunction

  // Exclusive end of a token that includes the current character, saturated.
  assign end_incl = (pos_r == POS_MAX) ? POS_MAX : pos_r + 1'b1;

  // Classification: close the open token, then maybe start a new one.
  always_comb begin
    mode_mid = mode_r;
    c_eff    = in_char;
    emit_a   = 1'b0;
    rec_a    = '0;
    unique case (mode_r)
      MODE_SLASH, MODE_WORD: begin
        if (mode_r == MODE_SLASH && in_char == CH_SLASH) begin
          mode_mid = MODE_COMMENT;
        end else if (is_delim(in_char)) begin
          emit_a       = 1'b1;
          rec_a.kind   = KIND_WORD;
          rec_a.offset = 16'(ts_r);
          rec_a.length = 16'(span_f(pos_r, ts_r));
          mode_mid     = MODE_IDLE;
        end else begin
          mode_mid = MODE_WORD;
        end
      end
      MODE_COMMENT: begin
        if (in_char == CH_NEWLINE) mode_mid = MODE_IDLE;
        c_eff = '0;
      end
      MODE_QUOTE: begin
        if (in_char == CH_DQUOTE) begin
          emit_a       = 1'b1;
          rec_a.kind   = KIND_QUOTED;
          rec_a.offset = 16'(ts_r);
          rec_a.length = 16'(span_f(end_incl, ts_r));
          rec_a.closed = 1'b1;
          mode_mid     = MODE_IDLE;
        end
        c_eff = '0;
      end
      default: mode_mid = MODE_IDLE;
    endcase

    // A new token may start at this character.
    mode_nxt = mode_mid;
    ts_nxt   = ts_r;
    emit_b   = 1'b0;
    rec_b    = '0;
    if (mode_mid == MODE_IDLE && !is_sep(c_eff)) begin
      if (c_eff == CH_SLASH) begin
        mode_nxt = MODE_SLASH;
        ts_nxt   = pos_r;
      end else if (c_eff == CH_DQUOTE) begin
        mode_nxt = MODE_QUOTE;
        ts_nxt   = pos_r;
      end else if (is_punct(c_eff)) begin
        emit_b           = 1'b1;
        rec_b.kind       = KIND_PUNCT;
        rec_b.offset     = 16'(pos_r);
        rec_b.length     = 16'd1;
        rec_b.punct_char = c_eff;
      end else begin
        mode_nxt = MODE_WORD;
        ts_nxt   = pos_r;
      end
    end

    // The end of the text flushes an open word or quoted group.
    if (in_fin) begin
      if (mode_nxt == MODE_WORD || mode_nxt == MODE_SLASH ||
          mode_nxt == MODE_QUOTE) begin
        emit_b       = 1'b1;
        rec_b        = '0;
        rec_b.kind   = (mode_nxt == MODE_QUOTE) ? KIND_QUOTED : KIND_WORD;
        rec_b.offset = 16'(ts_nxt);
        rec_b.length = 16'(span_f(end_incl, ts_nxt));
      end
      mode_nxt = MODE_IDLE;
      ts_nxt   = '0;
      pos_nxt  = '0;
    end else begin
      pos_nxt = end_incl;
    end
  end

  // Pack the records of this character into one queue entry.
  always_comb begin
    wr_en        = in_valid && (emit_a || emit_b);
    wr_data.two  = emit_a && emit_b;
    wr_data.rec0 = emit_a ? rec_a : rec_b;
    wr_data.rec1 = rec_b;
  end

  // Lexer state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '0;
      ts_r   <= '0;
    end else if (in_valid) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
    end
  end

endmodule

// ===== hdl/stl_fifo.sv =====
// Short queue of token entries between the front and the back end.
module stl_fifo #(
  parameter int DEPTH = stl_pkg::STL_FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  stl_pkg::stl_entry_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output stl_pkg::stl_entry_t rd_data,
  output logic                empty
);
  import stl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  stl_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== hdl/stl_back.sv =====
// Back end: hands out the records of each entry one beat at a time.
module stl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  stl_pkg::stl_entry_t rd_data,
  input  logic                q_empty,
  output logic                rd_en,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          out_kind,
  output logic [15:0]         out_offset,
  output logic [15:0]         out_length,
  output logic                out_closed,
  output logic [15:0]         out_punct_char,
  output logic                out_last_of_run
);
  import stl_pkg::*;

  stl_entry_t ent_r;
  logic       valid_r, half_r;
  logic       last, take, load;
  stl_rec_t   cur;

  assign last  = !ent_r.two || half_r;
  assign take  = pop && valid_r;
  assign load  = !q_empty && (!valid_r || (take && last));
  assign rd_en = load;
  assign empty = !valid_r;

  // Current record on the output.
  assign cur             = half_r ? ent_r.rec1 : ent_r.rec0;
  assign out_kind        = cur.kind;
  assign out_offset      = cur.offset;
  assign out_length      = cur.length;
  assign out_closed      = cur.closed;
  assign out_punct_char  = cur.punct_char;
  assign out_last_of_run = last;

  // Entry payload.
  always_ff @(posedge clk) begin
    if (load) ent_r <= rd_data;
  end

  // Output valid and which half of the entry is shown.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      half_r  <= 1'b0;
    end else if (take) begin
      if (last) begin
        valid_r <= 1'b0;
        half_r  <= 1'b0;
      end else begin
        half_r <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/stl_checker.sv =====
// Port-level checks for the script token splitter, bound to its top level.
module stl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_kind,
  input logic [15:0] out_offset,
  input logic [15:0] out_length,
  input logic        out_closed,
  input logic [15:0] out_punct_char
);
  import stl_pkg::*;

  // Reset leaves no record waiting and room for input.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("records or full flag survive reset");

  // No record appears without an earlier input beat.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    empty && !(push && !full) && !$past(push && !full) |=> empty)
    else $error("record appeared without an input beat");

  // A waiting record holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_kind) && $stable(out_offset) &&
                       $stable(out_length))
    else $error("waiting record changed");

  // Punctuation is one character and never closed.
  a_punct_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_kind == KIND_PUNCT |-> out_length == 16'd1 && !out_closed)
    else $error("bad punctuation record");

  // Only punctuation carries a character, only a quoted group a closed flag.
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_kind != KIND_PUNCT |->
      out_punct_char == 16'd0 && (out_kind == KIND_QUOTED || !out_closed))
    else $error("field set on wrong token kind");

endmodule

bind script_token_splitter stl_checker u_stl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .push          (push),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_kind      (out_kind),
  .out_offset    (out_offset),
  .out_length    (out_length),
  .out_closed    (out_closed),
  .out_punct_char(out_punct_char)
);

// ===== tb/sv/tb_script_token_splitter.sv =====
// Self-checking testbench for the script token splitter: directed table and random texts.
module tb_script_token_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  import stl_pkg::*;

  localparam int              HOLD_CYCLES = 200;
  localparam int              DRAIN_SLACK = 8;
  localparam int              RANDOM_CHARS = 1700;
  localparam longint unsigned POS_MAX = (64'd1 << STL_POS_BITS) - 1;

  // Lexer modes of the predictor.
  typedef enum logic [2:0] {
    LEX_IDLE,
    LEX_WORD,
    LEX_SLASH,
    LEX_QUOTE,
    LEX_COMMENT
  } lex_mode_t;

  // One token record as it leaves the block, with the end-of-run flag.
  typedef struct packed {
    stl_rec_t rec;
    logic     last;
  } token_beat_t;

  // One row of the directed script; rec is used only where typed is set.
  typedef struct packed {
    logic [15:0] ch;
    logic        fin;
    logic        typed;
    stl_rec_t    rec;
  } script_row_t;

  localparam stl_rec_t NO_REC = '0;

  localparam logic [15:0] PUNCT_CHARS [6] = '{
    CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_APOS, CH_COLON
  };

  // Directed script: punctuation, extremes, comments, lone slashes, quotes, end of text.
  localparam script_row_t DIRECTED_SCRIPT [25] = '{
    '{CH_LPAREN,  1'b0, 1'b1, '{KIND_PUNCT, 16'd0, 16'd1, 1'b0, CH_LPAREN}},
    '{16'hFFFF,   1'b0, 1'b0, NO_REC},
    '{CH_COLON,   1'b0, 1'b0, NO_REC},
    '{16'h0000,   1'b0, 1'b0, NO_REC},
    '{CH_SLASH,   1'b0, 1'b0, NO_REC},
    '{CH_SLASH,   1'b0, 1'b0, NO_REC},
    '{16'h0078,   1'b0, 1'b0, NO_REC},
    '{CH_DQUOTE,  1'b0, 1'b0, NO_REC},
    '{CH_NEWLINE, 1'b0, 1'b0, NO_REC},
    '{CH_SLASH,   1'b0, 1'b0, NO_REC},
    '{16'h0061,   1'b0, 1'b0, NO_REC},
    '{CH_DQUOTE,  1'b0, 1'b0, NO_REC},
    '{CH_SPACE,   1'b0, 1'b0, NO_REC},
    '{CH_DQUOTE,  1'b0, 1'b1, '{KIND_QUOTED, 16'd11, 16'd3, 1'b1, 16'd0}},
    '{CH_LBRACE,  1'b0, 1'b1, '{KIND_PUNCT, 16'd14, 16'd1, 1'b0, CH_LBRACE}},
    '{CH_RBRACE,  1'b0, 1'b1, '{KIND_PUNCT, 16'd15, 16'd1, 1'b0, CH_RBRACE}},
    '{CH_APOS,    1'b0, 1'b1, '{KIND_PUNCT, 16'd16, 16'd1, 1'b0, CH_APOS}},
    '{CH_RPAREN,  1'b0, 1'b1, '{KIND_PUNCT, 16'd17, 16'd1, 1'b0, CH_RPAREN}},
    '{CH_SLASH,   1'b0, 1'b0, NO_REC},
    '{16'h0021,   1'b1, 1'b0, NO_REC},
    '{CH_DQUOTE,  1'b0, 1'b0, NO_REC},
    '{16'h0071,   1'b1, 1'b1, '{KIND_QUOTED, 16'd0, 16'd2, 1'b0, 16'd0}},
    '{CH_SLASH,   1'b1, 1'b1, '{KIND_WORD, 16'd0, 16'd1, 1'b0, 16'd0}},
    '{CH_SPACE,   1'b1, 1'b0, NO_REC},
    '{16'h007A,   1'b1, 1'b1, '{KIND_WORD, 16'd0, 16'd1, 1'b0, 16'd0}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [15:0] in_character;
  logic        in_final_char;
  logic        empty;
  logic        pop;
  logic [1:0]  out_kind;
  logic [15:0] out_offset;
  logic [15:0] out_length;
  logic        out_closed;
  logic [15:0] out_punct_char;
  logic        out_last_of_run;

  // Predictor state.
  lex_mode_t       lex_mode;
  longint unsigned lex_pos;
  longint unsigned tok_start;

  token_beat_t pending_tokens[$];
  logic [15:0] draft[$];
  int          fault_count = 0;
  int          chars_sent = 0;
  bit          steady = 1'b0;
  int          hold_req = 0;

  script_token_splitter i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_character    (in_character),
    .in_final_char   (in_final_char),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_offset      (out_offset),
    .out_length      (out_length),
    .out_closed      (out_closed),
    .out_punct_char  (out_punct_char),
    .out_last_of_run (out_last_of_run)
  );

  always #4 clk = ~clk;

  // Hard limit on the run time.
  initial begin
    #4_000_000;
    $display("** script_token_splitter: FAILED **");
    $finish;
  end

  function automatic bit is_punct(input logic [15:0] ch);
    return ch == CH_LBRACE || ch == CH_RBRACE || ch == CH_LPAREN ||
           ch == CH_RPAREN || ch == CH_APOS || ch == CH_COLON;
  endfunction

  function automatic longint unsigned end_incl();
    return (lex_pos >= POS_MAX) ? POS_MAX : lex_pos + 1;
  endfunction

  function automatic stl_rec_t make_token(input logic [1:0] kind, input longint unsigned stop,
                                          input logic closed, input logic [15:0] pc);
    stl_rec_t t;
    t.kind       = kind;
    t.offset     = 16'(tok_start);
    t.length     = 16'((stop >= tok_start) ? stop - tok_start : 0);
    t.closed     = closed;
    t.punct_char = pc;
    return t;
  endfunction

  // Advance the lexer by one character and return the tokens it closes.
  function automatic int lex_char(input logic [15:0] ch_in, input logic fin,
                                  output token_beat_t t0, output token_beat_t t1);
    logic [15:0] ch;
    token_beat_t toks [2];
    int          n;
    ch = ch_in;
    n = 0;
    toks[0] = '0;
    toks[1] = '0;

    // Finish or continue the token that is already open.
    if (lex_mode == LEX_SLASH && ch == CH_SLASH) begin
      lex_mode = LEX_COMMENT;
    end else if (lex_mode == LEX_WORD || lex_mode == LEX_SLASH) begin
      if (ch <= CH_SPACE || is_punct(ch) || ch == CH_DQUOTE) begin
        toks[n].rec = make_token(KIND_WORD, lex_pos, 1'b0, 16'd0);
        n++;
        lex_mode = LEX_IDLE;
      end else begin
        lex_mode = LEX_WORD;
      end
    end else if (lex_mode == LEX_COMMENT) begin
      if (ch == CH_NEWLINE) lex_mode = LEX_IDLE;
      ch = '0;
    end else if (lex_mode == LEX_QUOTE) begin
      if (ch == CH_DQUOTE) begin
        toks[n].rec = make_token(KIND_QUOTED, end_incl(), 1'b1, 16'd0);
        n++;
        lex_mode = LEX_IDLE;
      end
      ch = '0;
    end

    // Start a new token on a character that is not a separator.
    if (lex_mode == LEX_IDLE && ch > CH_SPACE) begin
      if (ch == CH_SLASH) begin
        lex_mode  = LEX_SLASH;
        tok_start = lex_pos;
      end else if (ch == CH_DQUOTE) begin
        lex_mode  = LEX_QUOTE;
        tok_start = lex_pos;
      end else if (is_punct(ch)) begin
        toks[n].rec = '{KIND_PUNCT, 16'(lex_pos), 16'd1, 1'b0, ch};
        n++;
      end else begin
        lex_mode  = LEX_WORD;
        tok_start = lex_pos;
      end
    end

    // The end of the text flushes any open token and rewinds the position.
    if (fin) begin
      if (lex_mode == LEX_WORD || lex_mode == LEX_SLASH) begin
        toks[n].rec = make_token(KIND_WORD, end_incl(), 1'b0, 16'd0);
        n++;
      end else if (lex_mode == LEX_QUOTE) begin
        toks[n].rec = make_token(KIND_QUOTED, end_incl(), 1'b0, 16'd0);
        n++;
      end
      lex_mode  = LEX_IDLE;
      lex_pos   = 0;
      tok_start = 0;
    end else begin
      lex_pos = end_incl();
    end

    if (n > 0) toks[n-1].last = 1'b1;
    t0 = toks[0];
    t1 = toks[1];
    return n;
  endfunction

  // Offer one character beat; called at a falling edge and returns at a falling edge once it is accepted.
  task automatic offer_char(input logic [15:0] ch, input logic fin, input logic typed,
                            input stl_rec_t rec);
    token_beat_t t0;
    token_beat_t t1;
    int          n;
    while (!steady && $urandom_range(99) < 14) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push          <= 1'b1;
    in_character  <= ch;
    in_final_char <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    n = lex_char(ch, fin, t0, t1);
    if (typed) begin
      pending_tokens.push_back('{rec, 1'b1});
    end else begin
      if (n > 0) pending_tokens.push_back(t0);
      if (n > 1) pending_tokens.push_back(t1);
    end
    chars_sent++;
    @(negedge clk);
  endtask

  // Stop sending until every expected token has been taken.
  task automatic drain_tokens();
    push <= 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  function automatic logic [15:0] word_char();
    if ($urandom_range(1) == 0) return 16'h0061 + 16'($urandom_range(25));
    return 16'($urandom_range(16'h0021, 16'hFFFF));
  endfunction

  // Append one random but mostly well-formed piece of text to the draft.
  function automatic void add_piece();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 30) begin
      n = $urandom_range(1, 6);
      repeat (n) draft.push_back(word_char());
    end else if (r < 45) begin
      n = $urandom_range(1, 3);
      repeat (n) draft.push_back(16'($urandom_range(0, 32)));
    end else if (r < 55) begin
      draft.push_back(PUNCT_CHARS[$urandom_range(5)]);
    end else if (r < 63) begin
      draft.push_back(CH_SLASH);
      draft.push_back(CH_SLASH);
      n = $urandom_range(0, 5);
      repeat (n) draft.push_back(16'($urandom));
      if ($urandom_range(9) != 0) draft.push_back(CH_NEWLINE);
    end else if (r < 75) begin
      draft.push_back(CH_DQUOTE);
      n = $urandom_range(0, 6);
      repeat (n) draft.push_back($urandom_range(3) == 0 ? CH_SPACE : word_char());
      if ($urandom_range(99) < 85) draft.push_back(CH_DQUOTE);
    end else if (r < 82) begin
      draft.push_back(CH_SLASH);
    end else if (r < 90) begin
      draft.push_back(CH_DQUOTE);
    end else begin
      draft.push_back(16'($urandom));
    end
  endfunction

  // Send the draft as one text, marking its last character.
  task automatic send_draft();
    foreach (draft[i]) offer_char(draft[i], i == draft.size() - 1, 1'b0, NO_REC);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    int hold_left;
    int hold_seen;
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(99) >= 14);
    end
  end

  // Compare each token beat with the oldest expectation.
  always @(posedge clk) begin
    token_beat_t want;
    bit          bad;
    if (rst_n && pop && !empty) begin
      if (pending_tokens.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("Unexpected token: kind %0d offset %0d length %0d", out_kind,
                   out_offset, out_length);
      end else begin
        want = pending_tokens.pop_front();
        bad = (out_kind !== want.rec.kind) || (out_offset !== want.rec.offset) ||
              (out_length !== want.rec.length) || (out_closed !== want.rec.closed) ||
              (out_punct_char !== want.rec.punct_char) || (out_last_of_run !== want.last);
        if (bad) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("Token mismatch: expected k%0d o%0d l%0d c%0d p%h r%0d",
                     want.rec.kind, want.rec.offset, want.rec.length, want.rec.closed,
                     want.rec.punct_char, want.last);
            $display("                got      k%0d o%0d l%0d c%0d p%h r%0d",
                     out_kind, out_offset, out_length, out_closed, out_punct_char,
                     out_last_of_run);
          end
        end
      end
    end
  end

  // Main stimulus sequence.
  initial begin
    bit held;
    bit drained;
    rst_n         = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    in_character  = '0;
    in_final_char = 1'b0;
    lex_mode      = LEX_IDLE;
    lex_pos       = 0;
    tok_start     = 0;
    held          = 1'b0;
    drained       = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed script.
    foreach (DIRECTED_SCRIPT[i])
      offer_char(DIRECTED_SCRIPT[i].ch, DIRECTED_SCRIPT[i].fin, DIRECTED_SCRIPT[i].typed,
                 DIRECTED_SCRIPT[i].rec);
    drain_tokens();

    // Random texts, with a long receiver hold-off, a steady stretch and a full drain.
    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      if (!held && chars_sent >= 400) begin
        hold_req++;
        held = 1'b1;
      end
      steady = (chars_sent >= 800 && chars_sent < 1100);
      if (!drained && chars_sent >= 1300) begin
        drain_tokens();
        drained = 1'b1;
      end
      draft.delete();
      repeat ($urandom_range(1, 8)) add_piece();
      send_draft();
    end
    steady = 1'b0;

    drain_tokens();
    if (fault_count == 0) begin
      $display("** script_token_splitter: PASSED **");
    end else begin
      $display("** script_token_splitter: FAILED **");
    end
    $finish;
  end

endmodule

// ===== script_token_splitter.f =====
hdl/stl_pkg.sv
hdl/stl_front.sv
hdl/stl_fifo.sv
hdl/stl_back.sv
hdl/script_token_splitter.sv
hdl/stl_checker.sv
tb/sv/tb_script_token_splitter.sv
